[src/assert_macros.svh]
// Assertion macros shared by the scaler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NORST(label, clk, prop, msg)
`endif
`endif

[src/nnis_pkg.sv]
// Package: constants, types and helpers of the nearest neighbour scaler
package nnis_pkg;
   localparam int MaxSide    = 256;
   localparam int PixelBits  = 32;
   localparam int CoordBits  = 8;
   localparam int SizeBits   = 9;
   localparam int AddrBits   = 16;
   localparam int StoreDepth = MaxSide * MaxSide;
   localparam int ProdBits   = CoordBits + SizeBits;   // row * size
   localparam int QBits      = CoordBits;              // quotient < size <= 256
   localparam int DivSteps   = QBits;

   localparam logic [1:0] RegSrcWidth  = 2'd0;
   localparam logic [1:0] RegSrcHeight = 2'd1;
   localparam logic [1:0] RegDstWidth  = 2'd2;
   localparam logic [1:0] RegDstHeight = 2'd3;
   localparam int         CsrIdxBits   = 8;

   localparam logic ActWrite = 1'b0;
   localparam logic ActRead  = 1'b1;

   // one classified word passed from the front end to the back end
   typedef struct packed {
      logic                   is_write;
      logic                   range_err;
      logic [CoordBits-1:0]   row;
      logic [CoordBits-1:0]   col;
      logic [PixelBits-1:0]   pixel;
   } cmd_type;

   typedef struct packed {
      logic [SizeBits-1:0] sw;
      logic [SizeBits-1:0] sh;
      logic [SizeBits-1:0] dw;
      logic [SizeBits-1:0] dh;
   } sizes_type;

   // clamp a register to 1..MaxSide
   function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] r);
      logic [SizeBits-1:0] res;
      res = r;
      if (r == '0) res = SizeBits'(1);
      else if (r > SizeBits'(MaxSide)) res = SizeBits'(MaxSide);
      return res;
   endfunction
endpackage

[src/nnis_stream_if.sv]
// Interfaces: valid/ready channels for requests and responses
interface nnis_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [nnis_pkg::CoordBits-1:0]      pixel_row;
   logic [nnis_pkg::CoordBits-1:0]      pixel_col;
   logic [nnis_pkg::PixelBits-1:0]      pixel_in;
   modport source (output valid, action, pixel_row, pixel_col, pixel_in, input ready);
   modport sink (input valid, action, pixel_row, pixel_col, pixel_in, output ready);
endinterface

interface nnis_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [nnis_pkg::PixelBits-1:0]      pixel_out;
   logic                                range_error;
   modport source (output valid, pixel_out, range_error, input ready);
   modport sink (input valid, pixel_out, range_error, output ready);
endinterface

[src/nnis_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module nnis_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[src/nnis_front.sv]
// Front end: range check of incoming words, small queue toward the back end
module nnis_front (
   input  logic                  clock,
   input  logic                  reset,
   nnis_req_if.sink              req,
   input  nnis_pkg::sizes_type   sizes,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output nnis_pkg::cmd_type     cmd
);
   `include "assert_macros.svh"

   localparam int Depth = 4;
   localparam int PtrBits = 2;

   nnis_pkg::cmd_type    q_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]     cnt_ff, cnt_in;
   logic                 push, pop, drop;
   nnis_pkg::cmd_type    cls;

   // classify: writes outside the source are dropped here
   always_comb begin
      cls.is_write  = (req.action == nnis_pkg::ActWrite);
      cls.row       = req.pixel_row;
      cls.col       = req.pixel_col;
      cls.pixel     = req.pixel_in;
      cls.range_err = ({1'b0, req.pixel_row} >= sizes.dh) ||
                      ({1'b0, req.pixel_col} >= sizes.dw);
      drop          = cls.is_write && (({1'b0, req.pixel_row} >= sizes.sh) ||
                      ({1'b0, req.pixel_col} >= sizes.sw));
   end

   assign req.ready = (cnt_ff != (PtrBits+1)'(Depth));
   assign push      = req.valid && req.ready && !drop;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(push);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      cnt_in    = cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

   `ASSERT_CLK(a_cnt_max, clock, reset, cnt_ff <= (PtrBits+1)'(Depth), "queue overflow")
   `ASSERT_CLK(a_cnt_ptr, clock, reset,
      (cnt_ff == '0 || cnt_ff == (PtrBits+1)'(Depth)) == (wr_ptr_ff == rd_ptr_ff),
      "queue pointers disagree with count")
   `ASSERT_CLK(a_drop_nopush, clock, reset, drop |-> !push, "dropped write pushed")
endmodule

[src/nnis_back.sv]
// Back end: pipelined scaling dividers, store access, output skid
module nnis_back (
   input  logic                  clock,
   input  logic                  reset,
   input  nnis_pkg::sizes_type   sizes,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  nnis_pkg::cmd_type     cmd,
   nnis_rsp_if.source            rsp
);
   `include "assert_macros.svh"

   localparam int S  = nnis_pkg::DivSteps;
   localparam int PB = nnis_pkg::ProdBits;
   localparam int SB = nnis_pkg::SizeBits;
   localparam int CB = nnis_pkg::CoordBits;
   localparam int AB = nnis_pkg::AddrBits;
   localparam int XB = nnis_pkg::PixelBits;
   // stages: 0 multiply, 1..S divide steps, S+1 address, S+2 ram read
   localparam int NSt = S + 3;
   localparam int OutDepth = 16;  // > reads the pipe can hold, so reads stream one per cycle while responses are taken
   localparam int CntBits = $clog2(NSt + OutDepth + 1);
   localparam int OPtr = 4;

   logic                 advance;
   logic [NSt-1:0]       vld_ff;
   logic                 wr_ff  [NSt];
   logic                 err_ff [NSt];
   logic [PB-1:0]        rrem_ff [S+1];
   logic [PB-1:0]        crem_ff [S+1];
   logic [CB-1:0]        rq_ff [S+1];
   logic [CB-1:0]        cq_ff [S+1];
   logic [CB-1:0]        wrow_ff [S+2];
   logic [CB-1:0]        wcol_ff [S+2];
   logic [XB-1:0]        wpix_ff [S+2];
   logic [AB-1:0]        addr_ff;
   logic [XB-1:0]        ram_q;
   logic                 ram_we;
   logic [AB-1:0]        waddr_full, raddr_full;

   // space check: results already in flight plus buffered never exceed the buffer
   logic [CntBits-1:0]   inflight;
   logic [OPtr:0]        ocnt_ff;
   always_comb begin
      inflight = CntBits'(ocnt_ff);
      for (int i = 0; i < NSt; i++)
         inflight = inflight + CntBits'(vld_ff[i] && !wr_ff[i]);
   end
   assign advance   = 1'b1;
   assign cmd_ready = (inflight < CntBits'(OutDepth));

   logic take;
   assign take = cmd_valid && cmd_ready;

   // stage 0: products row*sh and col*sw
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[NSt-2:0], take};
   end

   always_ff @(posedge clock) begin
      wr_ff[0]   <= cmd.is_write;
      err_ff[0]  <= cmd.range_err;
      rrem_ff[0] <= PB'(cmd.row) * PB'(sizes.sh);
      crem_ff[0] <= PB'(cmd.col) * PB'(sizes.sw);
      rq_ff[0]   <= '0;
      cq_ff[0]   <= '0;
      wrow_ff[0] <= cmd.row;
      wcol_ff[0] <= cmd.col;
      wpix_ff[0] <= cmd.pixel;
      for (int i = 1; i < NSt; i++) begin
         wr_ff[i]  <= wr_ff[i-1];
         err_ff[i] <= err_ff[i-1];
      end
      for (int i = 1; i < S + 2; i++) begin
         wrow_ff[i] <= wrow_ff[i-1];
         wcol_ff[i] <= wcol_ff[i-1];
         wpix_ff[i] <= wpix_ff[i-1];
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar g = 1; g <= S; g++) begin : g_div
      localparam int Sh = S - g;
      logic [PB-1:0] rtrial, ctrial;
      assign rtrial = PB'(sizes.dh) << Sh;
      assign ctrial = PB'(sizes.dw) << Sh;
      always_ff @(posedge clock) begin
         if (rrem_ff[g-1] >= rtrial) begin
            rrem_ff[g] <= rrem_ff[g-1] - rtrial;
            rq_ff[g]   <= rq_ff[g-1] | CB'(1 << Sh);
         end else begin
            rrem_ff[g] <= rrem_ff[g-1];
            rq_ff[g]   <= rq_ff[g-1];
         end
         if (crem_ff[g-1] >= ctrial) begin
            crem_ff[g] <= crem_ff[g-1] - ctrial;
            cq_ff[g]   <= cq_ff[g-1] | CB'(1 << Sh);
         end else begin
            crem_ff[g] <= crem_ff[g-1];
            cq_ff[g]   <= cq_ff[g-1];
         end
      end
   end

   // stage S+1: address srow*sw+scol; writes use row*sw+col at the same place
   // (both stay below sw*sh <= StoreDepth, so AddrBits hold them exactly)
   assign raddr_full = AB'(rq_ff[S]) * AB'(sizes.sw) + AB'(cq_ff[S]);
   assign waddr_full = AB'(wrow_ff[S+1]) * AB'(sizes.sw) + AB'(wcol_ff[S+1]);
   always_ff @(posedge clock) addr_ff <= raddr_full;

   // write at stage S+1 keeps program order with reads at the ram read stage
   assign ram_we = vld_ff[S+1] && wr_ff[S+1];

   nnis_ram #(.Width(XB), .Depth(nnis_pkg::StoreDepth)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (waddr_full),
      .wr_data (wpix_ff[S+1]),
      .rd_en   (vld_ff[S+1] && !wr_ff[S+1] && !err_ff[S+1]),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   // output buffer
   typedef struct packed {
      logic [XB-1:0] pix;
      logic          err;
   } res_type;
   res_type          ob_ff [OutDepth];
   logic [OPtr-1:0]  owp_ff, orp_ff;
   logic             opush, opop;
   res_type          newres;

   assign opush = vld_ff[NSt-1] && !wr_ff[NSt-1];
   assign newres.err = err_ff[NSt-1];
   assign newres.pix = err_ff[NSt-1] ? '0 : ram_q;
   assign rsp.valid = (ocnt_ff != '0);
   assign rsp.pixel_out = ob_ff[orp_ff].pix;
   assign rsp.range_error = ob_ff[orp_ff].err;
   assign opop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff  <= owp_ff + OPtr'(opush);
         orp_ff  <= orp_ff + OPtr'(opop);
         ocnt_ff <= ocnt_ff + (OPtr+1)'(opush) - (OPtr+1)'(opop);
      end
   end
   always_ff @(posedge clock) begin
      if (opush) ob_ff[owp_ff] <= newres;
   end

   `ASSERT_CLK(a_ob_room, clock, reset, opush |-> (ocnt_ff < (OPtr+1)'(OutDepth)) || opop,
      "output buffer overrun")
   `ASSERT_CLK(a_err_zero, clock, reset, rsp.valid && rsp.range_error |-> rsp.pixel_out == '0,
      "range error with nonzero pixel")
   `ASSERT_CLK(a_adv, clock, reset, advance, "pipeline stalled")
endmodule

[src/nearest_neighbour_image_scaler_top.sv]
// Top level of the nearest neighbour image scaler
//
//  channel | dir | words                         | handshake
//  req_    | in  | action, pixel_row/col, pix_in | valid/ready
//  rsp_    | out | pixel_out, range_error        | valid/ready
//  csr_    | in  | wr_en, index, 9-bit data      | write enable only
//
// One word per cycle is accepted while req_ready is high; a read passes through the
// queue, multiply, eight divider stages, address, store read and output buffer.
// The front queue holds four words; the back end takes a word only while the
// 16-entry output buffer has room for every read in flight. Writes make no response.
// Reset (synchronous) sets all sizes to 1 and empties queues; store undefined.
module nearest_neighbour_image_scaler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [nnis_pkg::CoordBits-1:0]       req_pixel_row,
   input  logic [nnis_pkg::CoordBits-1:0]       req_pixel_col,
   input  logic [nnis_pkg::PixelBits-1:0]       req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [nnis_pkg::PixelBits-1:0]       rsp_pixel_out,
   output logic                                 rsp_range_error,
   input  logic                                 csr_wr_en,
   input  logic [nnis_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [nnis_pkg::SizeBits-1:0]        csr_data
);
   nnis_req_if req ();
   nnis_rsp_if rsp ();

   assign req.valid     = req_valid;
   assign req.action    = req_action;
   assign req.pixel_row = req_pixel_row;
   assign req.pixel_col = req_pixel_col;
   assign req.pixel_in  = req_pixel_in;
   assign req_ready     = req.ready;
   assign rsp_valid       = rsp.valid;
   assign rsp_pixel_out   = rsp.pixel_out;
   assign rsp_range_error = rsp.range_error;
   assign rsp.ready       = rsp_ready;

   // size registers: raw bits kept, clamped copy feeds the datapath
   logic [nnis_pkg::SizeBits-1:0] sw_ff, sh_ff, dw_ff, dh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= nnis_pkg::SizeBits'(1);
         sh_ff <= nnis_pkg::SizeBits'(1);
         dw_ff <= nnis_pkg::SizeBits'(1);
         dh_ff <= nnis_pkg::SizeBits'(1);
      end else if (csr_wr_en && csr_index[nnis_pkg::CsrIdxBits-1:2] == '0) begin
         case (csr_index[1:0])
            nnis_pkg::RegSrcWidth:  sw_ff <= csr_data;
            nnis_pkg::RegSrcHeight: sh_ff <= csr_data;
            nnis_pkg::RegDstWidth:  dw_ff <= csr_data;
            nnis_pkg::RegDstHeight: dh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   nnis_pkg::sizes_type sizes;
   assign sizes.sw = nnis_pkg::eff_size(sw_ff);
   assign sizes.sh = nnis_pkg::eff_size(sh_ff);
   assign sizes.dw = nnis_pkg::eff_size(dw_ff);
   assign sizes.dh = nnis_pkg::eff_size(dh_ff);

   logic              cmd_valid, cmd_ready;
   nnis_pkg::cmd_type cmd;

   nnis_front u_front (
      .clock (clock), .reset (reset), .req (req.sink), .sizes (sizes),
      .cmd_valid (cmd_valid), .cmd_ready (cmd_ready), .cmd (cmd)
   );

   nnis_back u_back (
      .clock (clock), .reset (reset), .sizes (sizes),
      .cmd_valid (cmd_valid), .cmd_ready (cmd_ready), .cmd (cmd), .rsp (rsp.source)
   );
endmodule
